// ===== rtl/core/panel_window_pixel_writer_unit_defines.svh =====
// Assertion macros shared by the pixel writer RTL.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef PANEL_WINDOW_PIXEL_WRITER_UNIT_DEFINES_SVH
`define PANEL_WINDOW_PIXEL_WRITER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PWPW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PWPW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/pwpw_pkg.sv =====
package pwpw_pkg;

    // Panel geometry of the frame store.
    localparam int PANEL_WIDTH  = 240;
    localparam int PANEL_HEIGHT = 240;

    localparam int COL_W       = $clog2(PANEL_WIDTH);
    localparam int ROW_W       = $clog2(PANEL_HEIGHT);
    localparam int FULL_ADDR_W = COL_W + ROW_W + 1;
    localparam int ADDR_W      = 16;
    localparam int COLOR_W     = 16;
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_INDEX_W = 3;
    localparam int WIN_POS_W   = 10;
    localparam int WIN_SIZE_W  = 9;
    localparam int POINT_W     = 11;
    localparam int COORD_W     = 13;

    localparam logic [1:0] ROT_MASK = 2'h3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROTATION = 3'd0,
        REG_WIN_X    = 3'd1,
        REG_WIN_Y    = 3'd2,
        REG_WIN_W    = 3'd3,
        REG_WIN_H    = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    typedef enum logic [1:0] {
        ST_WRITTEN   = 2'd0,
        ST_OFF_PANEL = 2'd1,
        ST_OVERRUN   = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    // Window cursor.
    typedef struct packed {
        logic [WIN_SIZE_W-1:0] col;
        logic [WIN_SIZE_W-1:0] row;
    } cursor_t;

    // Contents of the input register: the request with its window point.
    typedef struct packed {
        logic [COLOR_W-1:0]        color;
        logic                      eob;
        status_t                   status;
        logic signed [POINT_W-1:0] x;
        logic signed [POINT_W-1:0] y;
    } stage_t;

endpackage

// ===== rtl/core/pwpw_cursor.sv =====
module pwpw_cursor (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   accept,
    input  logic                                   win_clear,
    input  logic [pwpw_pkg::WIN_POS_W-1:0]         win_x,
    input  logic [pwpw_pkg::WIN_POS_W-1:0]         win_y,
    input  logic [pwpw_pkg::WIN_SIZE_W-1:0]        win_w,
    input  logic [pwpw_pkg::WIN_SIZE_W-1:0]        win_h,
    input  logic [pwpw_pkg::COLOR_W-1:0]           pixel_color,
    input  logic                                   end_of_burst,
    output pwpw_pkg::stage_t                       stage,
    output pwpw_pkg::cursor_t                      cursor
);

    pwpw_pkg::cursor_t cursor_reg, cursor_next;
    pwpw_pkg::stage_t  stage_reg, stage_next;
    logic [pwpw_pkg::WIN_SIZE_W-1:0] col_inc;
    logic empty_win;
    logic overrun;

    always_comb begin
        empty_win = (win_w == '0) || (win_h == '0);
        overrun   = (cursor_reg.row >= win_h);
        col_inc   = cursor_reg.col + 1'b1;

        stage_next.color = pixel_color;
        stage_next.eob   = end_of_burst;
        stage_next.x     = $signed({win_x[pwpw_pkg::WIN_POS_W-1], win_x})
                         + $signed({2'b00, cursor_reg.col});
        stage_next.y     = $signed({win_y[pwpw_pkg::WIN_POS_W-1], win_y})
                         + $signed({2'b00, cursor_reg.row});
        cursor_next      = cursor_reg;

        if (empty_win) begin
            stage_next.status = pwpw_pkg::ST_EMPTY;
        end else if (overrun) begin
            stage_next.status = pwpw_pkg::ST_OVERRUN;
        end else begin
            // Whether it lands on the panel is decided in the next stage.
            stage_next.status = pwpw_pkg::ST_WRITTEN;
            if (accept) begin
                if ((col_inc >= win_w) || (col_inc == '0)) begin
                    cursor_next.col = '0;
                    cursor_next.row = cursor_reg.row + 1'b1;
                end else begin
                    cursor_next.col = col_inc;
                end
            end
        end

        if (win_clear) begin
            cursor_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= '0;
        end else begin
            cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stage_reg <= stage_next;
        end
    end

    assign stage  = stage_reg;
    assign cursor = cursor_reg;

endmodule

// ===== rtl/core/pwpw_map.sv =====
module pwpw_map (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               load,
    input  logic                               stage_valid,
    input  pwpw_pkg::stage_t                   stage,
    input  logic [1:0]                         rotation,
    output logic                               out_valid,
    output logic                               write_enable,
    output logic [pwpw_pkg::ADDR_W-1:0]        write_address,
    output logic [pwpw_pkg::COLOR_W-1:0]       write_data,
    output pwpw_pkg::status_t                  status,
    output logic                               burst_done
);

    localparam logic signed [pwpw_pkg::COORD_W-1:0] PW_C =
        pwpw_pkg::COORD_W'(pwpw_pkg::PANEL_WIDTH);
    localparam logic signed [pwpw_pkg::COORD_W-1:0] PH_C =
        pwpw_pkg::COORD_W'(pwpw_pkg::PANEL_HEIGHT);
    // Last column and last row of the panel, used by the rotated mappings.
    localparam logic signed [pwpw_pkg::COORD_W-1:0] PW_LAST_C =
        pwpw_pkg::COORD_W'(pwpw_pkg::PANEL_WIDTH - 1);
    localparam logic signed [pwpw_pkg::COORD_W-1:0] PH_LAST_C =
        pwpw_pkg::COORD_W'(pwpw_pkg::PANEL_HEIGHT - 1);
    localparam logic [pwpw_pkg::FULL_ADDR_W-1:0] PW_MUL =
        pwpw_pkg::FULL_ADDR_W'(pwpw_pkg::PANEL_WIDTH);

    logic signed [pwpw_pkg::COORD_W-1:0] x_ext, y_ext, px, py;
    logic [pwpw_pkg::FULL_ADDR_W-1:0]    addr_full;
    logic                                on_panel;

    logic                          valid_reg, valid_next;
    logic                          we_reg, we_next;
    logic [pwpw_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [pwpw_pkg::COLOR_W-1:0]  data_reg;
    pwpw_pkg::status_t             status_reg, status_next;
    logic                          done_reg;

    always_comb begin
        x_ext = pwpw_pkg::COORD_W'(stage.x);
        y_ext = pwpw_pkg::COORD_W'(stage.y);
        unique case (pwpw_pkg::rot_t'(rotation & pwpw_pkg::ROT_MASK))
            pwpw_pkg::ROT_90: begin
                px = PW_LAST_C - y_ext;
                py = x_ext;
            end
            pwpw_pkg::ROT_180: begin
                px = PW_LAST_C - x_ext;
                py = PH_LAST_C - y_ext;
            end
            pwpw_pkg::ROT_270: begin
                px = y_ext;
                py = PH_LAST_C - x_ext;
            end
            default: begin
                px = x_ext;
                py = y_ext;
            end
        endcase

        on_panel  = (px >= 0) && (px < PW_C) && (py >= 0) && (py < PH_C);
        addr_full = pwpw_pkg::FULL_ADDR_W'(py[pwpw_pkg::ROW_W-1:0]) * PW_MUL
                  + pwpw_pkg::FULL_ADDR_W'(px[pwpw_pkg::COL_W-1:0]);

        we_next     = 1'b0;
        addr_next   = '0;
        status_next = stage.status;
        if (stage.status == pwpw_pkg::ST_WRITTEN) begin
            if (on_panel) begin
                we_next   = 1'b1;
                addr_next = pwpw_pkg::ADDR_W'(addr_full);
            end else begin
                status_next = pwpw_pkg::ST_OFF_PANEL;
            end
        end

        valid_next = load ? stage_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            we_reg     <= we_next;
            addr_reg   <= addr_next;
            data_reg   <= stage.color;
            status_reg <= status_next;
            done_reg   <= stage.eob;
        end
    end

    assign out_valid     = valid_reg;
    assign write_enable  = we_reg;
    assign write_address = addr_reg;
    assign write_data    = data_reg;
    assign status        = status_reg;
    assign burst_done    = done_reg;

endmodule

// ===== rtl/core/panel_window_pixel_writer_unit.sv =====
// Address-window pixel writer. Each request on the slave stream carries one
// RGB565 pixel; the block walks the configured window in raster order,
// offsets the cursor by the window origin, rotates the point by a multiple
// of a quarter turn as set by the rotation register, and issues one
// frame-store write request (enable, address, data, status) per pixel on
// the master stream. One pixel is taken per clock cycle while the master
// stream is not stalled: the first register holds the pixel with its window
// point and advances the cursor, the second does the rotation, panel bounds
// check and the row times width address product. An accepted pixel goes to
// the input register and its result to the result register, from which it
// is presented on the master stream, and the pipeline keeps taking pixels
// while a finished result waits for m_tready, as long as its first register
// is free. Writing any window register (origin or size) returns the cursor
// to the window's top left corner; writing rotation does not. Configuration
// should only change while no pixel is in flight.
`include "panel_window_pixel_writer_unit_defines.svh"

module panel_window_pixel_writer_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [pwpw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pwpw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Pixel stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,  // [15:0] pixel_color
    input  logic                                s_tlast,  // end_of_burst
    // Frame-store write stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [31:0]                         m_tdata,  // [15:0] write_address,
                                                          // [31:16] write_data
    output logic [2:0]                          m_tuser,  // [0] write_enable,
                                                          // [2:1] status
    output logic                                m_tlast   // burst_done
);

    // Configuration registers.
    logic [1:0]                         rotation_reg;
    logic [pwpw_pkg::WIN_POS_W-1:0]     win_x_reg;
    logic [pwpw_pkg::WIN_POS_W-1:0]     win_y_reg;
    logic [pwpw_pkg::WIN_SIZE_W-1:0]    win_w_reg;
    logic [pwpw_pkg::WIN_SIZE_W-1:0]    win_h_reg;
    logic                               win_write;

    // Pipeline control.
    logic                               s_accept;
    logic                               out_adv;
    logic                               stage_valid_reg, stage_valid_next;
    pwpw_pkg::stage_t                   stage;
    pwpw_pkg::cursor_t                  cursor;

    logic                               write_enable;
    logic [pwpw_pkg::ADDR_W-1:0]        write_address;
    logic [pwpw_pkg::COLOR_W-1:0]       write_data;
    pwpw_pkg::status_t                  status;
    logic                               burst_done;

    // A write to any of the window registers restarts the cursor.
    assign win_write = cfg_wr_en
        && (cfg_index inside {pwpw_pkg::REG_WIN_X, pwpw_pkg::REG_WIN_Y,
                              pwpw_pkg::REG_WIN_W, pwpw_pkg::REG_WIN_H});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rotation_reg <= '0;
            win_x_reg    <= '0;
            win_y_reg    <= '0;
            win_w_reg    <= '0;
            win_h_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pwpw_pkg::REG_ROTATION: rotation_reg <= cfg_wdata[1:0] & pwpw_pkg::ROT_MASK;
                pwpw_pkg::REG_WIN_X:    win_x_reg    <= cfg_wdata;
                pwpw_pkg::REG_WIN_Y:    win_y_reg    <= cfg_wdata;
                pwpw_pkg::REG_WIN_W:    win_w_reg    <= cfg_wdata[pwpw_pkg::WIN_SIZE_W-1:0];
                pwpw_pkg::REG_WIN_H:    win_h_reg    <= cfg_wdata[pwpw_pkg::WIN_SIZE_W-1:0];
                default: ; // Indexes past the last register are ignored.
            endcase
        end
    end

    // The result register moves when it is empty or being drained; the
    // input register moves when it is empty or its content moves on.
    assign out_adv          = !m_tvalid || m_tready;
    assign s_tready         = !stage_valid_reg || out_adv;
    assign s_accept         = s_tvalid && s_tready;
    assign stage_valid_next = s_tready ? s_tvalid : stage_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    pwpw_cursor u_cursor (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (s_accept),
        .win_clear    (win_write),
        .win_x        (win_x_reg),
        .win_y        (win_y_reg),
        .win_w        (win_w_reg),
        .win_h        (win_h_reg),
        .pixel_color  (s_tdata),
        .end_of_burst (s_tlast),
        .stage        (stage),
        .cursor       (cursor)
    );

    pwpw_map u_map (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (out_adv),
        .stage_valid   (stage_valid_reg),
        .stage         (stage),
        .rotation      (rotation_reg),
        .out_valid     (m_tvalid),
        .write_enable  (write_enable),
        .write_address (write_address),
        .write_data    (write_data),
        .status        (status),
        .burst_done    (burst_done)
    );

    assign m_tdata = {write_data, write_address};
    assign m_tuser = {status, write_enable};
    assign m_tlast = burst_done;

    // The pipeline never takes a pixel while both registers are full and
    // the output is stalled.
    `PWPW_ASSERT_SAME(a_no_accept_when_full,
        stage_valid_reg && m_tvalid && !m_tready, !s_tready,
        "pixel accepted while pipeline full")

    // A window register write returns the cursor to the window's corner.
    `PWPW_ASSERT_NEXT(a_cursor_cleared, win_write, cursor == '0,
        "cursor not cleared by window register write")

    // The cursor row never runs more than one past the window's last row.
    `PWPW_ASSERT_NEXT(a_row_in_window,
        s_accept && !win_write && (cursor.row < win_h_reg),
        cursor.row <= win_h_reg,
        "cursor row ran past the window")

endmodule
